// ===== hw/rtl/srde_pkg.sv =====
// Shared types, constants and helper function for the signed radix digit emitter.
package srde_pkg;

    // Alphabet limits and data widths.
    localparam int MAX_SYMBOLS  = 16;
    localparam int VALUE_W      = 32;
    localparam int CHAR_W       = 8;
    localparam int LEN_W        = 5;
    localparam int DIGIT_W      = 4;
    localparam int SYMS_W       = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int STACK_DEPTH  = 32;
    localparam int CNT_W        = 6;
    localparam int DIV_STEPS    = 4;
    localparam int BITS_PER_STEP = VALUE_W / DIV_STEPS;
    localparam int STEP_W       = 2;

    // Register reset values: radix ten with the symbols "0123456789".
    localparam logic [LEN_W-1:0]  ALPHA_LEN_RST = 5'd10;
    localparam logic [SYMS_W-1:0] SYMS_LO_RST   = 64'h3736_3534_3332_3130;
    localparam logic [SYMS_W-1:0] SYMS_HI_RST   = 64'h0000_0000_0000_3938;

    // Character codes.
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'd43;
    localparam logic [CHAR_W-1:0] CHAR_PCT   = 8'd37;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'd47;
    localparam logic [CHAR_W-1:0] CHAR_STAR  = 8'd42;
    localparam logic [CHAR_W-1:0] CHAR_EQ    = 8'd61;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'd44;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'd46;
    localparam logic [CHAR_W-1:0] SYM_MIN    = 8'd33;
    localparam logic [CHAR_W-1:0] SYM_MAX    = 8'd126;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMS_LO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMS_HI   = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_EMIT
    } t_state;

    // Request to the shared divider.
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [LEN_W-1:0]   divisor;
    } t_div_req;

    // Result from the shared divider.
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } t_div_rsp;

    // A symbol byte that may not appear in an alphabet.
    function automatic logic is_forbidden(input logic [CHAR_W-1:0] c);
        return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_PCT) ||
               (c == CHAR_SLASH) || (c == CHAR_STAR) || (c == CHAR_EQ) ||
               (c == CHAR_COMMA) || (c == CHAR_DOT) ||
               (c < SYM_MIN) || (c > SYM_MAX);
    endfunction

endpackage

// ===== hw/rtl/srde_divider.sv =====
// Iterative divider of a 32-bit magnitude by a small radix, eight quotient bits per cycle.
module srde_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  srde_pkg::t_div_req i_req,
    output srde_pkg::t_div_rsp o_rsp
);
    import srde_pkg::*;

    logic [VALUE_W-1:0] r_work;
    logic [DIGIT_W-1:0] r_rem;
    logic [LEN_W-1:0]   r_div;
    logic [STEP_W-1:0]  r_step;
    logic               r_busy;
    logic               r_done;

    logic [VALUE_W-1:0] n_work;
    logic [DIGIT_W-1:0] n_rem;

    // One cycle of restoring division: eight shift, compare and subtract steps.
    always_comb begin
        logic [LEN_W-1:0]   rem;
        logic [VALUE_W-1:0] work;
        rem  = {1'b0, r_rem};
        work = r_work;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            rem  = {rem[DIGIT_W-1:0], work[VALUE_W-1]};
            work = {work[VALUE_W-2:0], 1'b0};
            if (rem >= r_div) begin
                rem     = rem - r_div;
                work[0] = 1'b1;
            end
        end
        n_work = work;
        n_rem  = rem[DIGIT_W-1:0];
    end

    // Control: a start loads the operands; the busy steps in r_step finish the division.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (r_busy) begin
            r_step <= r_step + 1'b1;
            if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_work <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_work;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== hw/rtl/signed_radix_digit_emitter.sv =====
// Top level of the signed radix digit emitter: configuration, sequencer and digit stack.
//
// Usage: a signed 32-bit value arrives on the input channel (i_in_valid, o_in_stall)
// and leaves as a run of characters on the output channel (o_out_valid, i_out_stall),
// most significant digit first, preceded by '-' for a negative value. o_last_char marks
// the final character of a run. The radix and the digit symbols come from three
// registers written through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle.
// If the alphabet is invalid, a request is taken and produces no characters.
// Timing: each digit takes a pass through the shared divider (division steps at eight
// quotient bits each, then the result is handed back and pushed on the stack); the
// characters then leave one per cycle while the receiver does not stall. The most
// negative value gives eleven characters in decimal and 33 characters in binary.
// The block takes one request at a time and holds o_in_stall high until the last
// character is in the output register.
// A stall from the receiver holds the output register and pauses the emission.
// Reset (synchronous, active low) clears the sequencer and the output valid, and
// restores the alphabet to radix ten with the symbols 0 to 9.
module signed_radix_digit_emitter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [srde_pkg::VALUE_W-1:0] i_value,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [srde_pkg::CHAR_W-1:0]     o_out_char,
    output logic                            o_last_char,
    input  logic                            i_cfg_we,
    input  logic [srde_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [srde_pkg::SYMS_W-1:0]     i_cfg_data
);
    import srde_pkg::*;

    // Configuration registers.
    logic [LEN_W-1:0]  r_alpha_len;
    logic [SYMS_W-1:0] r_syms_lo;
    logic [SYMS_W-1:0] r_syms_hi;

    // Sequencer and datapath state.
    t_state             r_state, n_state;
    logic               r_neg;
    logic [DIGIT_W-1:0] r_stack [STACK_DEPTH];
    logic [CNT_W-1:0]   r_cnt;
    logic               r_out_valid;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_last;

    logic               in_acc;
    logic               alpha_ok;
    logic [VALUE_W-1:0] mag;
    logic [2*SYMS_W-1:0] sym_bytes;
    logic [CHAR_W-1:0]  top_sym;
    logic               load_out;
    logic               push;
    logic               pop;
    logic [CHAR_W-1:0]  n_out_char;
    logic               n_last;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    // Configuration writes; an index past the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_len <= ALPHA_LEN_RST;
            r_syms_lo   <= SYMS_LO_RST;
            r_syms_hi   <= SYMS_HI_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ALPHA_LEN: r_alpha_len <= i_cfg_data[LEN_W-1:0];
                CFG_SYMS_LO:   r_syms_lo   <= i_cfg_data;
                CFG_SYMS_HI:   r_syms_hi   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign sym_bytes = {r_syms_hi, r_syms_lo};

    // Alphabet check: length in range, no forbidden byte, no repeated symbol.
    always_comb begin
        logic ok;
        ok = (r_alpha_len >= LEN_W'(2)) && (r_alpha_len <= LEN_W'(MAX_SYMBOLS));
        for (int i = 0; i < MAX_SYMBOLS; i++) begin
            if (LEN_W'(i) < r_alpha_len) begin
                if (is_forbidden(sym_bytes[i*CHAR_W +: CHAR_W])) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
                    if ((LEN_W'(j) < r_alpha_len) &&
                        (sym_bytes[j*CHAR_W +: CHAR_W] == sym_bytes[i*CHAR_W +: CHAR_W])) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        alpha_ok = ok;
    end

    // Input handshake and magnitude of the incoming value.
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign mag        = i_value[VALUE_W-1] ? (~i_value + 1'b1) : i_value;

    // Symbol of the digit on top of the stack.
    assign top_sym = sym_bytes[{r_stack[0], 3'b000} +: CHAR_W];

    // The output register can take a new character when empty or being drained.
    assign load_out = ((r_state == S_SIGN) || (r_state == S_EMIT)) &&
                      (!r_out_valid || !i_out_stall);

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && alpha_ok) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done && (div_rsp.quotient == '0)) begin
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                if (load_out) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (load_out && (r_cnt == CNT_W'(1))) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output logic of the sequencer: divider requests, stack moves, next character.
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = mag;
        div_req.divisor  = r_alpha_len;
        push       = 1'b0;
        pop        = 1'b0;
        n_out_char = CHAR_MINUS;
        n_last     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                div_req.start = in_acc && alpha_ok;
            end
            S_DIV: begin
                push             = div_rsp.done;
                div_req.dividend = div_rsp.quotient;
                div_req.start    = div_rsp.done && (div_rsp.quotient != '0);
            end
            S_SIGN: begin
                n_out_char = CHAR_MINUS;
            end
            S_EMIT: begin
                pop        = load_out;
                n_out_char = top_sym;
                n_last     = (r_cnt == CNT_W'(1));
            end
            default: ;
        endcase
    end

    // Sequencer control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Sign capture and output payload.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_neg <= i_value[VALUE_W-1];
        end
        if (load_out) begin
            r_out_char <= n_out_char;
            r_last     <= n_last;
        end
    end

    // Digit stack: remainders are pushed least significant first and popped in reverse.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_stack[0] <= div_rsp.remainder;
            for (int i = 1; i < STACK_DEPTH; i++) begin
                r_stack[i] <= r_stack[i-1];
            end
        end else if (pop) begin
            for (int i = 0; i < STACK_DEPTH - 1; i++) begin
                r_stack[i] <= r_stack[i+1];
            end
        end
    end

    // Shared divider.
    srde_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_last_char = r_last;

    // The stack never holds more digits than a 32-bit magnitude has.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(STACK_DEPTH))
        else $error("digit stack overflow");

    // A divider result only arrives while the sequencer waits for it.
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside of division state");

    // Every remainder is a valid digit of the radix.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> ({1'b0, div_rsp.remainder} < r_alpha_len))
        else $error("remainder not below radix");

    // Loading the last character empties the stack and frees the input.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && load_out && (r_cnt == CNT_W'(1))) |=>
            ((r_state == S_IDLE) && (r_cnt == '0) && o_last_char))
        else $error("run did not end with the last character");

endmodule
